// ===== rtl/csmc_pkg.sv =====
// ----------------------------------------------------------------------------
// csmc_pkg
// Shared widths, codes and state type of the circular shift match counter.
// ----------------------------------------------------------------------------
package csmc_pkg;

    localparam int DATA_W  = 8;
    localparam int SHIFT_W = 13;
    localparam int COUNT_W = 13;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

    typedef logic [DATA_W-1:0]  t_byte;
    typedef logic [SHIFT_W-1:0] t_shift;

endpackage

// ===== rtl/csmc_mem.sv =====
// ----------------------------------------------------------------------------
// csmc_mem
// Byte store: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module csmc_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  csmc_pkg::t_byte i_wr_data,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr_a,
    input  logic [AW-1:0]   i_rd_addr_b,
    output csmc_pkg::t_byte o_rd_data_a,
    output csmc_pkg::t_byte o_rd_data_b
);

    csmc_pkg::t_byte r_mem [DEPTH];
    csmc_pkg::t_byte r_rd_a;
    csmc_pkg::t_byte r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== rtl/csmc_mod.sv =====
// ----------------------------------------------------------------------------
// csmc_mod
// Restoring remainder unit: shift modulo block length, one bit per cycle.
// ----------------------------------------------------------------------------
module csmc_mod #(
    parameter int LW = 13,
    parameter int AW = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  csmc_pkg::t_shift   i_dividend,
    input  logic [LW-1:0]      i_divisor,
    output logic               o_done,
    output logic [AW-1:0]      o_rem
);

    localparam int CNT_W = $clog2(csmc_pkg::SHIFT_W + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    csmc_pkg::t_shift    r_dvd;
    logic [LW-1:0]       r_dvs;
    logic [LW-1:0]       r_rem;
    logic [LW:0]         trial;
    logic [LW:0]         n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[csmc_pkg::SHIFT_W-1]};
        if (trial >= {1'b0, r_dvs}) begin
            n_rem = trial - {1'b0, r_dvs};
        end else begin
            n_rem = trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(csmc_pkg::SHIFT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[csmc_pkg::SHIFT_W-2:0], 1'b0};
            r_rem <= n_rem[LW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[AW-1:0];

endmodule

// ===== rtl/circular_shift_match_counter.sv =====
// ----------------------------------------------------------------------------
// circular_shift_match_counter
// Byte block store answering circular shift coincidence queries.
// ----------------------------------------------------------------------------
// A load request (tuser 0) writes one byte in one cycle; tlast closes the
// block, and the next load starts a new one. Bytes past STORE_DEPTH are
// dropped. A query request (tuser 1) on a block of length L passes through
// the bit-serial remainder unit, which reduces the shift, a step that starts
// the walk, a walk that issues one pair of store reads on the two read ports
// for each of the L bytes, a compare stage and the result register. The
// input reopens once the result is registered. A query with no block loaded
// goes straight to the result register, with tuser set and a zero count, and
// the input reopens once that result is registered. Input is refused while a
// query is in progress; the result register lets the next request in while a
// result waits.
module circular_shift_match_counter #(
    parameter int STORE_DEPTH = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] data_byte, [20:8] shift
    input  logic        s_axis_tuser,   // [0] func
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [12:0] match_count, [25:13] shift_echo
    output logic        m_axis_tuser    // [0] no_data
);

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int LW = $clog2(STORE_DEPTH + 1);
    localparam int CW = (LW > csmc_pkg::COUNT_W) ? LW : csmc_pkg::COUNT_W;

    csmc_pkg::t_state r_state;
    logic             r_loading;
    logic             r_ready;
    logic [LW-1:0]    r_wp;
    logic [LW-1:0]    r_len;
    csmc_pkg::t_shift r_shift;
    logic             r_nodata;
    logic             r_issue;
    logic             r_cmp_v;
    logic             r_cmp_last;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_jdx;
    logic [LW-1:0]    r_cnt;
    logic             r_out_valid;
    logic [csmc_pkg::COUNT_W-1:0] r_out_count;
    csmc_pkg::t_shift r_out_shift;
    logic             r_out_nodata;

    logic             in_acc;
    logic             ld_acc;
    logic             qry_acc;
    logic [LW-1:0]    wp_eff;
    logic             wr_ok;
    logic             idx_last;
    logic             jdx_wrap;
    logic             out_free;
    logic             mod_done;
    logic [AW-1:0]    mod_rem;
    csmc_pkg::t_byte  rd_a;
    csmc_pkg::t_byte  rd_b;
    logic [CW-1:0]    cnt_ext;

    assign s_axis_tready = (r_state == csmc_pkg::ST_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign ld_acc  = in_acc && (s_axis_tuser == csmc_pkg::FUNC_LOAD);
    assign qry_acc = in_acc && (s_axis_tuser == csmc_pkg::FUNC_QUERY);

    assign wp_eff   = r_loading ? r_wp : '0;
    assign wr_ok    = wp_eff < LW'(STORE_DEPTH);
    assign idx_last = (LW'(r_idx) + LW'(1)) == r_len;
    assign jdx_wrap = (LW'(r_jdx) + LW'(1)) == r_len;
    assign out_free = !r_out_valid || m_axis_tready;
    assign cnt_ext  = CW'(r_cnt);

    csmc_mem #(
        .DEPTH(STORE_DEPTH),
        .AW   (AW)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (ld_acc && wr_ok),
        .i_wr_addr  (wp_eff[AW-1:0]),
        .i_wr_data  (s_axis_tdata[7:0]),
        .i_rd_en    (r_issue),
        .i_rd_addr_a(r_idx),
        .i_rd_addr_b(r_jdx),
        .o_rd_data_a(rd_a),
        .o_rd_data_b(rd_b)
    );

    csmc_mod #(
        .LW(LW),
        .AW(AW)
    ) u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (qry_acc && r_ready && (r_len != '0)),
        .i_dividend(s_axis_tdata[20:8]),
        .i_divisor (r_len),
        .o_done    (mod_done),
        .o_rem     (mod_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csmc_pkg::ST_IDLE;
            r_loading   <= 1'b0;
            r_ready     <= 1'b0;
            r_wp        <= '0;
            r_len       <= '0;
            r_issue     <= 1'b0;
            r_cmp_v     <= 1'b0;
            r_cmp_last  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && (r_state != csmc_pkg::ST_DONE)) begin
                r_out_valid <= 1'b0;
            end
            r_cmp_v    <= r_issue;
            r_cmp_last <= r_issue && idx_last;
            case (r_state)
                csmc_pkg::ST_IDLE: begin
                    if (ld_acc) begin
                        if (s_axis_tlast) begin
                            r_len     <= wp_eff + LW'(wr_ok);
                            r_ready   <= 1'b1;
                            r_loading <= 1'b0;
                            r_wp      <= '0;
                        end else begin
                            r_ready   <= 1'b0;
                            r_loading <= 1'b1;
                            r_wp      <= wp_eff + LW'(wr_ok);
                        end
                    end else if (qry_acc) begin
                        if (r_ready && (r_len != '0)) begin
                            r_state <= csmc_pkg::ST_DIV;
                        end else begin
                            r_state <= csmc_pkg::ST_DONE;
                        end
                    end
                end
                csmc_pkg::ST_DIV: begin
                    if (mod_done) begin
                        r_state <= csmc_pkg::ST_SCAN;
                        r_issue <= 1'b1;
                    end
                end
                csmc_pkg::ST_SCAN: begin
                    if (r_issue && idx_last) begin
                        r_issue <= 1'b0;
                    end
                    if (r_cmp_v && r_cmp_last) begin
                        r_state <= csmc_pkg::ST_DONE;
                    end
                end
                csmc_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= csmc_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= csmc_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // scan pointers, count and result payload
    always_ff @(posedge i_clk) begin
        if (qry_acc) begin
            r_shift  <= s_axis_tdata[20:8];
            r_nodata <= !(r_ready && (r_len != '0));
            r_cnt    <= '0;
        end
        if (mod_done) begin
            r_idx <= '0;
            r_jdx <= mod_rem;
        end else if (r_issue) begin
            r_idx <= r_idx + AW'(1);
            r_jdx <= jdx_wrap ? '0 : r_jdx + AW'(1);
        end
        if (r_cmp_v && (rd_a == rd_b)) begin
            r_cnt <= r_cnt + LW'(1);
        end
        if ((r_state == csmc_pkg::ST_DONE) && out_free) begin
            r_out_count  <= cnt_ext[csmc_pkg::COUNT_W-1:0];
            r_out_shift  <= r_shift;
            r_out_nodata <= r_nodata;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_shift, r_out_count};
    assign m_axis_tuser  = r_out_nodata;

endmodule

// ===== rtl/csmc_checker.sv =====
// ----------------------------------------------------------------------------
// csmc_checker
// Port-level checks of the circular shift match counter, bound to the top.
// ----------------------------------------------------------------------------
module csmc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic        s_axis_tuser,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_nodata_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[31:13] == 19'd0 ||
        m_axis_tdata[12:0] == 13'd0)
        else $error("no_data result with non-zero count");

    a_nodata_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[12:0] == 13'd0)
        else $error("no_data result carries a count");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("request taken right after a query");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind circular_shift_match_counter csmc_checker u_csmc_checker (.*);

// ===== sim/tb_circular_shift_match_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_shift_match_counter
// Self-checking bench for the circular shift match counter.
// ----------------------------------------------------------------------------
// Load and query requests are queued up front and fed by a clocked driver.
// Each accepted load updates a local image of the byte block, and each
// query computes its coincidence count from that image. A clocked monitor
// compares every answer in order. Both stream sides idle at random, the
// answer side is held off for a long stretch once, and the driver drains all
// answers before selected requests.
// ----------------------------------------------------------------------------
module tb_circular_shift_match_counter;

    localparam int STORE_DEPTH = 4096;
    localparam int HOLD_CYCLES = 400;
    localparam csmc_pkg::t_byte PAT [8] = '{8'hFF, 8'h00, 8'hFF, 8'h00,
                                            8'hAA, 8'h55, 8'hFF, 8'h00};

    typedef struct {
        logic             func;
        csmc_pkg::t_byte  data;
        logic             last;
        csmc_pkg::t_shift shift;
        bit               hold_off;   // wait until every answer is back
    } t_req;

    typedef struct {
        logic [csmc_pkg::COUNT_W-1:0] count;
        csmc_pkg::t_shift             shift;
        logic                         no_data;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;    // [7:0] data_byte, [20:8] shift
    logic        s_axis_tuser = 1'b0;  // [0] func
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_ready = 1'b0;
    logic [31:0] m_axis_tdata;         // [12:0] match_count, [25:13] shift_echo
    logic        m_axis_tuser;         // [0] no_data

    t_req    req_q[$];
    t_answer answer_q[$];
    t_req    cur_req;
    t_answer head_ans;

    // block image
    csmc_pkg::t_byte img_bytes [STORE_DEPTH];
    int    img_len   = 0;
    int    img_wr    = 0;
    bit    img_ready = 1'b0;
    bit    img_open  = 1'b0;

    int n_accepted = 0;
    int hold_at    = -1;
    int hold_left  = 0;
    int err_cnt    = 0;
    int n_loads    = 0;
    int n_queries  = 0;
    int n_nodata   = 0;
    int max_count  = 0;
    logic calm;

    assign calm = (n_accepted >= 60) && (n_accepted < 100);

    circular_shift_match_counter #(
        .STORE_DEPTH(STORE_DEPTH)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_valid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_ready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #2_000_000;
        $display("timeout: %0d answers outstanding", answer_q.size());
        $display("== FAIL ==");
        $finish;
    end

    task automatic report(input string msg);
        err_cnt++;
        if (err_cnt <= 40)
            $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic predict_coincidence(input t_req r);
        t_answer a;
        int      s;
        int      j;
        int      hits;
        if (r.func == csmc_pkg::FUNC_LOAD) begin
            n_loads++;
            if (!img_open) begin
                img_open  = 1'b1;
                img_ready = 1'b0;
                img_wr    = 0;
            end
            if (img_wr < STORE_DEPTH) begin
                img_bytes[img_wr] = r.data;
                img_wr++;
            end
            if (r.last) begin
                img_len   = img_wr;
                img_ready = 1'b1;
                img_open  = 1'b0;
                img_wr    = 0;
            end
        end else begin
            n_queries++;
            a.shift = r.shift;
            if (!img_ready || img_len == 0) begin
                a.count   = '0;
                a.no_data = 1'b1;
                n_nodata++;
            end else begin
                s    = int'(r.shift) % img_len;
                hits = 0;
                for (int i = 0; i < img_len; i++) begin
                    j = i + s;
                    if (j >= img_len)
                        j -= img_len;
                    if (img_bytes[i] == img_bytes[j])
                        hits++;
                end
                a.count   = hits[csmc_pkg::COUNT_W-1:0];
                a.no_data = 1'b0;
                if (hits > max_count)
                    max_count = hits;
            end
            answer_q.push_back(a);
        end
    endtask

    task automatic add_load(input csmc_pkg::t_byte d, input logic l, input bit hold);
        t_req r;
        r.func     = csmc_pkg::FUNC_LOAD;
        r.data     = d;
        r.last     = l;
        r.shift    = csmc_pkg::t_shift'($urandom_range(8191));
        r.hold_off = hold;
        req_q.push_back(r);
    endtask

    task automatic add_query(input csmc_pkg::t_shift sh, input bit hold);
        t_req r;
        r.func     = csmc_pkg::FUNC_QUERY;
        r.data     = csmc_pkg::t_byte'($urandom);
        r.last     = logic'($urandom_range(1));
        r.shift    = sh;
        r.hold_off = hold;
        req_q.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_axis_tready) begin
                predict_coincidence(cur_req);
                n_accepted <= n_accepted + 1;
            end
            if (!s_valid || s_axis_tready) begin
                if (req_q.size() != 0 && !(req_q[0].hold_off && answer_q.size() != 0)
                        && (calm || $urandom_range(99) >= 30)) begin
                    cur_req = req_q.pop_front();
                    s_axis_tdata <= {3'b000, cur_req.shift, cur_req.data};
                    s_axis_tuser <= cur_req.func;
                    s_axis_tlast <= cur_req.last;
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long hold-off on the answer side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (s_valid && s_axis_tready && n_accepted == hold_at) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_ready) begin
                if (answer_q.size() == 0) begin
                    report($sformatf("answer with none pending: count %0d shift %0d",
                                     m_axis_tdata[12:0], m_axis_tdata[25:13]));
                end else begin
                    head_ans = answer_q.pop_front();
                    if (m_axis_tdata[12:0] !== head_ans.count)
                        report($sformatf("shift %0d: count %0d, expected %0d",
                                         head_ans.shift, m_axis_tdata[12:0], head_ans.count));
                    if (m_axis_tdata[25:13] !== head_ans.shift)
                        report($sformatf("shift echo %0d, expected %0d",
                                         m_axis_tdata[25:13], head_ans.shift));
                    if (m_axis_tuser !== head_ans.no_data)
                        report($sformatf("shift %0d: no_data %b, expected %b",
                                         head_ans.shift, m_axis_tuser, head_ans.no_data));
                end
            end
            m_ready <= (hold_left == 0) && (calm || $urandom_range(99) >= 30);
        end
    end

    initial begin : stim
        int    n_dir;
        int    n_rand;
        int    blen;
        int    nq;
        int    alpha;
        csmc_pkg::t_byte sym [4];

        // no block yet
        add_query(13'd5, 1'b0);
        // one-byte block, shifts at both ends
        add_load(8'h00, 1'b1, 1'b0);
        add_query(13'h1FFF, 1'b0);
        add_query(13'd0, 1'b0);
        // eight-byte pattern block
        for (int k = 0; k < 8; k++)
            add_load(PAT[k], logic'(k == 7), 1'b0);
        hold_at = req_q.size();
        add_query(13'd1, 1'b0);
        add_query(13'd2, 1'b0);
        add_query(13'd8, 1'b0);
        add_query(13'h1555, 1'b0);
        add_query(13'h0AAA, 1'b0);
        // reopened block: queries see no data until closed
        add_load(8'hFF, 1'b0, 1'b0);
        add_load(8'h00, 1'b0, 1'b0);
        add_query(13'd3, 1'b0);
        add_load(8'h80, 1'b1, 1'b0);
        add_query(13'd4, 1'b1);
        n_dir = req_q.size();

        while (req_q.size() - n_dir < 120) begin
            if ($urandom_range(99) < 80) begin
                blen  = ($urandom_range(9) == 0) ? $urandom_range(41, 120)
                                                 : $urandom_range(1, 16);
                alpha = $urandom_range(1, 4);
                for (int k = 0; k < 4; k++)
                    sym[k] = csmc_pkg::t_byte'($urandom);
                for (int k = 0; k < blen; k++)
                    add_load(($urandom_range(7) == 0) ? csmc_pkg::t_byte'($urandom)
                                                      : sym[$urandom_range(alpha - 1)],
                             logic'(k == blen - 1),
                             (k == 0) && ($urandom_range(9) == 0));
                nq = $urandom_range(1, 4);
                for (int k = 0; k < nq; k++)
                    add_query(($urandom_range(1) == 1)
                                  ? csmc_pkg::t_shift'($urandom_range(1, 8191))
                                  : csmc_pkg::t_shift'($urandom_range(1, 2 * blen)),
                              1'b0);
            end else begin
                // open block left unfinished, then a query on it
                nq = $urandom_range(1, 3);
                for (int k = 0; k < nq; k++)
                    add_load(csmc_pkg::t_byte'($urandom), 1'b0, 1'b0);
                add_query(csmc_pkg::t_shift'($urandom_range(1, 8191)), 1'b0);
            end
        end
        n_rand = req_q.size() - n_dir;

        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        while (req_q.size() != 0 || s_valid)
            @(posedge i_clk);
        while (answer_q.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("Covered %0d directed and %0d random requests, incl. open and short blocks:",
                 n_dir, n_rand);
        $display("  %0d loads, %0d queries (%0d without a block), peak count %0d, %0d errors",
                 n_loads, n_queries, n_nodata, max_count, err_cnt);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
